// ===== src/grid_astar_path_search_unit_defines.svh =====
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit_defines
// Assertion macros shared by the path search unit.
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define GAS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define GAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GAS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/gas_pkg.sv =====
// ----------------------------------------------------------------------------
// gas_pkg
// Types, constants and helpers of the grid path search unit.
// ----------------------------------------------------------------------------
package gas_pkg;
  localparam int GridRows = 8;
  localparam int GridCols = 8;
  localparam int Cells    = GridRows * GridCols;
  localparam int IdxW     = $clog2(Cells);
  localparam int RowW     = 3;
  localparam int ColW     = 3;
  localparam int CostW    = 7;

  localparam logic [1:0] DirDown  = 2'd0;
  localparam logic [1:0] DirUp    = 2'd1;
  localparam logic [1:0] DirRight = 2'd2;
  localparam logic [1:0] DirLeft  = 2'd3;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpSearch = 1'b1;

  typedef struct packed {
    logic              op;
    logic [RowW-1:0]   cell_row;
    logic [ColW-1:0]   cell_col;
    logic              cell_blocked;
    logic [RowW-1:0]   start_row;
    logic [ColW-1:0]   start_col;
    logic [RowW-1:0]   goal_row;
    logic [ColW-1:0]   goal_col;
  } req_t;

  typedef struct packed {
    logic [RowW-1:0] path_row;
    logic [ColW-1:0] path_col;
    logic            found;
    logic            last;
  } rsp_t;

  // candidate travelling along the cell chain
  typedef struct packed {
    logic             vld;
    logic [CostW:0]   f;
    logic [CostW-1:0] g;
    logic [IdxW-1:0]  idx;
  } cand_t;

  // command broadcast from the sequencer to all cells
  typedef struct packed {
    logic             clear;
    logic             open_start;
    logic             close_en;
    logic [IdxW-1:0]  close_idx;
    logic             relax_en;
    logic [IdxW-1:0]  relax_idx;
    logic [CostW-1:0] relax_g;
    logic [1:0]       relax_dir;
  } cell_cmd_t;

  function automatic logic [RowW-1:0] absdiff3(input logic [RowW-1:0] a,
                                               input logic [RowW-1:0] b);
    absdiff3 = (a > b) ? a - b : b - a;
  endfunction

  // true when candidate a beats candidate b
  function automatic logic better(input cand_t a, input cand_t b);
    priority if (!a.vld)              better = 1'b0;
    else if (!b.vld)                  better = 1'b1;
    else if (a.f != b.f)              better = a.f < b.f;
    else if (a.g != b.g)              better = a.g > b.g;
    else                              better = a.idx < b.idx;
  endfunction
endpackage

// ===== src/gas_if.sv =====
// ----------------------------------------------------------------------------
// gas_req_if / gas_rsp_if / gas_cfg_if
// Valid/ready channels of the grid path search unit.
// ----------------------------------------------------------------------------
interface gas_req_if;
  logic            valid;
  logic            ready;
  gas_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gas_rsp_if;
  logic            valid;
  logic            ready;
  gas_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gas_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [3:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/gas_cell.sv =====
// ----------------------------------------------------------------------------
// gas_cell
// One grid cell: open/closed marks, cost, parent link, and one stage of the
// minimum chain.
// ----------------------------------------------------------------------------
module gas_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gas_pkg::IdxW-1:0]      my_idx_i,
  input  logic                          in_use_i,
  input  logic                          blocked_i,
  input  logic [gas_pkg::RowW-1:0]      goal_row_i,
  input  logic [gas_pkg::ColW-1:0]      goal_col_i,
  input  logic [gas_pkg::IdxW-1:0]      start_idx_i,
  input  gas_pkg::cell_cmd_t            cmd_i,
  input  gas_pkg::cand_t                chain_i,
  output gas_pkg::cand_t                chain_o,
  output logic                          open_o,
  output logic                          closed_o,
  output logic [gas_pkg::CostW-1:0]     g_o,
  output logic [1:0]                    dir_o
);
  import gas_pkg::*;

  logic             open_q, closed_q;
  logic [CostW-1:0] g_q;
  logic [1:0]       dir_q;
  cand_t            mine, chain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      closed_q <= 1'b0;
    end else if (cmd_i.clear) begin
      open_q   <= 1'b0;
      closed_q <= 1'b0;
    end else if (cmd_i.open_start && start_idx_i == my_idx_i) begin
      open_q <= 1'b1;
    end else if (cmd_i.close_en && cmd_i.close_idx == my_idx_i) begin
      open_q   <= 1'b0;
      closed_q <= 1'b1;
    end else if (cmd_i.relax_en && cmd_i.relax_idx == my_idx_i &&
                 !blocked_i && !closed_q && (!open_q || cmd_i.relax_g < g_q)) begin
      open_q <= 1'b1;
    end
  end

  // cost and parent: payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.open_start && start_idx_i == my_idx_i) begin
      g_q <= '0;
    end else if (cmd_i.relax_en && cmd_i.relax_idx == my_idx_i &&
                 !blocked_i && !closed_q && (!open_q || cmd_i.relax_g < g_q)) begin
      g_q   <= cmd_i.relax_g;
      dir_q <= cmd_i.relax_dir;
    end
  end

  always_comb begin
    mine.vld = open_q && in_use_i;
    mine.g   = g_q;
    mine.idx = my_idx_i;
    mine.f   = {1'b0, g_q}
             + {{(CostW+1-RowW){1'b0}}, absdiff3(my_idx_i[IdxW-1 -: RowW], goal_row_i)}
             + {{(CostW+1-ColW){1'b0}}, absdiff3(my_idx_i[ColW-1:0], goal_col_i)};
  end

  // hand the better of ours and the upstream candidate to the neighbour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) chain_q <= '0;
    else         chain_q <= better(mine, chain_i) ? mine : chain_i;
  end

  assign chain_o  = chain_q;
  assign open_o   = open_q;
  assign closed_o = closed_q;
  assign g_o      = g_q;
  assign dir_o    = dir_q;
endmodule

// ===== src/gas_seq.sv =====
// ----------------------------------------------------------------------------
// gas_seq
// Search sequencer: scan, expand, back-trace and path output.
// ----------------------------------------------------------------------------
`include "grid_astar_path_search_unit_defines.svh"
module gas_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gas_req_if.sink                       req,
  gas_rsp_if.source                     rsp,
  input  logic [3:0]                    rows_i,
  input  logic [3:0]                    cols_i,
  input  gas_pkg::cand_t                best_i,
  input  logic [gas_pkg::Cells-1:0]     open_i,
  input  logic [gas_pkg::Cells-1:0]     closed_i,
  input  logic [gas_pkg::CostW-1:0]     g_sel_i,
  input  logic [1:0]                    dir_sel_i,
  output logic [gas_pkg::IdxW-1:0]      sel_idx_o,
  output logic [gas_pkg::Cells-1:0]     blocked_o,
  output logic [gas_pkg::Cells-1:0]     in_use_o,
  output logic [gas_pkg::RowW-1:0]      goal_row_o,
  output logic [gas_pkg::ColW-1:0]      goal_col_o,
  output logic [gas_pkg::IdxW-1:0]      start_idx_o,
  output gas_pkg::cell_cmd_t            cmd_o
);
  import gas_pkg::*;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StInit  = 9'b000000010,
    StScan  = 9'b000000100,
    StPick  = 9'b000001000,
    StRelax = 9'b000010000,
    StTrace = 9'b000100000,
    StEmit  = 9'b001000000,
    StFail  = 9'b010000000,
    StWait  = 9'b100000000
  } state_e;

  localparam int CntW = IdxW + 1;

  state_e           state_q, state_d;
  logic [Cells-1:0] blocked_q;
  logic [RowW-1:0]  sr_q, gr_q;
  logic [ColW-1:0]  sc_q, gc_q;
  logic [CntW-1:0]  cnt_q;
  cand_t            best_q;
  logic [1:0]       dir_q;
  logic [IdxW-1:0]  trace_q;
  logic [CntW-1:0]  plen_q;
  logic [IdxW-1:0]  stack_q [Cells];
  logic             rsp_valid_q;
  rsp_t             rsp_q;
  logic [3:0]       er, ec;
  logic             endpoints_ok;
  logic signed [RowW+1:0] nr;
  logic signed [ColW+1:0] nc;
  logic             n_ok;
  logic [RowW-1:0]  tr_r, pr_r;
  logic [ColW-1:0]  tr_c, pc_r;

  assign er = (rows_i > 4'(GridRows)) ? 4'(GridRows) : rows_i;
  assign ec = (cols_i > 4'(GridCols)) ? 4'(GridCols) : cols_i;

  for (genvar i = 0; i < Cells; i++) begin : g_use
    assign in_use_o[i] = ({1'b0, 3'(i / GridCols)} < er) && ({1'b0, 3'(i % GridCols)} < ec);
  end

  assign endpoints_ok = ({1'b0, req.payload.start_row} < er) &&
                        ({1'b0, req.payload.start_col} < ec) &&
                        ({1'b0, req.payload.goal_row} < er) &&
                        ({1'b0, req.payload.goal_col} < ec);

  assign req.ready = (state_q == StIdle) && !rsp_valid_q;

  // neighbour of the expanded cell in direction dir_q
  always_comb begin
    nr = $signed({2'b00, best_q.idx[IdxW-1 -: RowW]});
    nc = $signed({2'b00, best_q.idx[ColW-1:0]});
    unique case (dir_q)
      DirDown:  nr = nr + 5'sd1;
      DirUp:    nr = nr - 5'sd1;
      DirRight: nc = nc + 5'sd1;
      DirLeft:  nc = nc - 5'sd1;
      default:  nr = nr;
    endcase
    n_ok = (nr >= 0) && (nc >= 0) && (nr < $signed({1'b0, er})) &&
           (nc < $signed({1'b0, ec}));
  end

  // step back from the traced cell against its parent direction
  always_comb begin
    tr_r = trace_q[IdxW-1 -: RowW];
    tr_c = trace_q[ColW-1:0];
    pr_r = tr_r;
    pc_r = tr_c;
    unique case (dir_sel_i)
      DirDown:  pr_r = tr_r - 3'd1;
      DirUp:    pr_r = tr_r + 3'd1;
      DirRight: pc_r = tr_c - 3'd1;
      DirLeft:  pc_r = tr_c + 3'd1;
      default:  pr_r = tr_r;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (req.valid && req.ready && req.payload.op == OpSearch) begin
                 state_d = endpoints_ok ? StInit : StFail;
               end
      StInit:  state_d = StScan;
      StScan:  if (cnt_q == CntW'(Cells)) state_d = StPick;
      StPick:  begin
                 priority if (!best_i.vld) state_d = StFail;
                 else if (best_i.idx == {gr_q, gc_q}) state_d = StTrace;
                 else state_d = StRelax;
               end
      StRelax: if (dir_q == DirLeft) state_d = StScan;
      StTrace: if (trace_q == {sr_q, sc_q} || plen_q == CntW'(Cells - 1)) state_d = StEmit;
      StEmit:  if (!rsp_valid_q || rsp.ready) begin
                 if (plen_q == CntW'(1)) state_d = StWait;
               end
      StFail:  if (!rsp_valid_q || rsp.ready) state_d = StWait;
      StWait:  if (!rsp_valid_q || rsp.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      blocked_q   <= '0;
      cnt_q       <= '0;
      dir_q       <= DirDown;
      plen_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp_valid_q && rsp.ready && state_q != StEmit && state_q != StFail) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req.valid && req.ready && req.payload.op == OpLoad) begin
            blocked_q[{req.payload.cell_row, req.payload.cell_col}] <= req.payload.cell_blocked;
          end
        end
        StInit:  cnt_q <= '0;
        StScan:  cnt_q <= cnt_q + CntW'(1);
        StPick:  begin
          cnt_q  <= '0;
          dir_q  <= DirDown;
          plen_q <= '0;
        end
        StRelax: dir_q <= dir_q + 2'd1;
        StTrace: plen_q <= plen_q + CntW'(1);
        StEmit:  if (!rsp_valid_q || rsp.ready) begin
          rsp_valid_q <= 1'b1;
          plen_q      <= plen_q - CntW'(1);
        end
        StFail:  if (!rsp_valid_q || rsp.ready) rsp_valid_q <= 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req.valid && req.ready) begin
      sr_q <= req.payload.start_row;
      sc_q <= req.payload.start_col;
      gr_q <= req.payload.goal_row;
      gc_q <= req.payload.goal_col;
    end
    if (state_q == StPick) begin
      best_q  <= best_i;
      trace_q <= {gr_q, gc_q};
    end
    if (state_q == StTrace) begin
      stack_q[plen_q[IdxW-1:0]] <= trace_q;
      trace_q <= {pr_r, pc_r};
    end
    if (state_q == StEmit && (!rsp_valid_q || rsp.ready)) begin
      rsp_q.path_row <= stack_q[plen_q[IdxW-1:0] - IdxW'(1)][IdxW-1 -: RowW];
      rsp_q.path_col <= stack_q[plen_q[IdxW-1:0] - IdxW'(1)][ColW-1:0];
      rsp_q.found    <= 1'b1;
      rsp_q.last     <= (plen_q == CntW'(1));
    end
    if (state_q == StFail && (!rsp_valid_q || rsp.ready)) begin
      rsp_q <= '{path_row: '0, path_col: '0, found: 1'b0, last: 1'b1};
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.clear      = (state_q == StIdle) && req.valid && req.ready &&
                       req.payload.op == OpSearch;
    cmd_o.open_start = (state_q == StInit);
    cmd_o.close_en   = (state_q == StPick) && best_i.vld && best_i.idx != {gr_q, gc_q};
    cmd_o.close_idx  = best_i.idx;
    cmd_o.relax_en   = (state_q == StRelax) && n_ok;
    cmd_o.relax_idx  = {nr[RowW-1:0], nc[ColW-1:0]};
    cmd_o.relax_g    = best_q.g + CostW'(1);
    cmd_o.relax_dir  = dir_q;
  end

  assign sel_idx_o   = trace_q;
  assign blocked_o   = blocked_q;
  assign goal_row_o  = gr_q;
  assign goal_col_o  = gc_q;
  assign start_idx_o = {sr_q, sc_q};
  assign rsp.valid   = rsp_valid_q;
  assign rsp.payload = rsp_q;

  `GAS_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, req.ready, state_q == StIdle)
  `GAS_ASSERT_IMP(a_open_closed, clk_i, rst_ni, 1'b1, (open_i & closed_i) == '0)
  `GAS_ASSERT_NEXT(a_fail_last, clk_i, rst_ni, state_q == StFail && (!rsp_valid_q || rsp.ready), rsp_valid_q && rsp_q.last)
  `GAS_ASSERT_IMP(a_trace_cost, clk_i, rst_ni, state_q == StTrace && trace_q != {sr_q, sc_q}, g_sel_i != '0)
endmodule

// ===== src/grid_astar_path_search_unit.sv =====
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit
// A* path search on an 8x8 grid, built from a chain of grid cells.
// ----------------------------------------------------------------------------
// Use: requests arrive on req. op=0 writes one cell's blocked bit and is taken
// with no result. op=1 searches from start to goal and returns the path on
// rsp, start first, one cell per result, last set on the goal; a failed
// search returns one result with found=0.
// Each cell holds its own marks, cost and parent. Every expansion streams
// the open cells through the cell chain to find the minimum, then picks it
// and relaxes its four neighbours in turn; a found path is then traced back
// from the goal cell by cell and emitted one cell per result.
// Reset clears the map to all open, the registers to 8 rows and 8 columns,
// and returns to idle. When rsp stalls, the result register holds and the
// sequencer waits; no new request is taken until the last result has gone.
// Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  gas_req_if.sink    req,
  gas_rsp_if.source  rsp,
  gas_cfg_if.sink    cfg
);
  import gas_pkg::*;

  logic [3:0]       rows_q, cols_q;
  cand_t            chain [Cells+1];
  cell_cmd_t        cmd;
  logic [Cells-1:0] open_v, closed_v, blocked_v, in_use_v;
  logic [CostW-1:0] g_v   [Cells];
  logic [1:0]       dir_v [Cells];
  logic [IdxW-1:0]  sel_idx, start_idx;
  logic [RowW-1:0]  goal_row;
  logic [ColW-1:0]  goal_col;

  assign cfg.ready = 1'b1;

  // hold the two size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 4'd8;
      cols_q <= 4'd8;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CfgRows: rows_q <= cfg.data;
        CfgCols: cols_q <= cfg.data;
        default: rows_q <= rows_q;
      endcase
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    gas_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .my_idx_i    (IdxW'(i)),
      .in_use_i    (in_use_v[i]),
      .blocked_i   (blocked_v[i]),
      .goal_row_i  (goal_row),
      .goal_col_i  (goal_col),
      .start_idx_i (start_idx),
      .cmd_i       (cmd),
      .chain_i     (chain[i]),
      .chain_o     (chain[i+1]),
      .open_o      (open_v[i]),
      .closed_o    (closed_v[i]),
      .g_o         (g_v[i]),
      .dir_o       (dir_v[i])
    );
  end

  gas_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .rsp         (rsp),
    .rows_i      (rows_q),
    .cols_i      (cols_q),
    .best_i      (chain[Cells]),
    .open_i      (open_v),
    .closed_i    (closed_v),
    .g_sel_i     (g_v[sel_idx]),
    .dir_sel_i   (dir_v[sel_idx]),
    .sel_idx_o   (sel_idx),
    .blocked_o   (blocked_v),
    .in_use_o    (in_use_v),
    .goal_row_o  (goal_row),
    .goal_col_o  (goal_col),
    .start_idx_o (start_idx),
    .cmd_o       (cmd)
  );
endmodule

// ===== dv/tb_grid_astar_path_search_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_astar_path_search_unit
// Self-checking bench for the grid path search unit: grid writes and
// searches go in on the request channel. Each returned path cell is compared
// against an in-bench A* predictor working over its own copy of the map.
// ----------------------------------------------------------------------------
module tb_grid_astar_path_search_unit;
  import gas_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gas_req_if req_if ();
  gas_rsp_if rsp_if ();
  gas_cfg_if cfg_if ();

  grid_astar_path_search_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if.sink),
    .rsp    (rsp_if.source),
    .cfg    (cfg_if.sink)
  );

  // 10 ns period: low half, then high half
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: own copy of the map and the two size registers
  logic       blocked_q [Cells];
  logic [3:0] rows_q;
  logic [3:0] cols_q;
  rsp_t       path_q [$];
  int         fail_cnt;
  logic       hold_rsp;   // long stall of the result side
  int         hold_cycles;

  // Work out the path cells that one search request gives
  function automatic void predict_path(input req_t r);
    int  er, ec, gr, gc, sr, sc;
    int  best, bf, bg, br, bc, f, g, idx, tr, tc, ti, n;
    int  cost [Cells];
    int  dir [Cells];
    bit  opn [Cells];
    bit  cls [Cells];
    bit  reached;
    int  trail [$];
    rsp_t o;
    er = (rows_q > 4'd8) ? 8 : int'(rows_q);
    ec = (cols_q > 4'd8) ? 8 : int'(cols_q);
    sr = int'(r.start_row); sc = int'(r.start_col);
    gr = int'(r.goal_row);  gc = int'(r.goal_col);
    reached = 1'b0;
    if (sr < er && sc < ec && gr < er && gc < ec) begin
      for (int i = 0; i < Cells; i++) begin
        opn[i] = 0; cls[i] = 0; cost[i] = 0; dir[i] = 0;
      end
      opn[sr*8+sc] = 1;
      forever begin
        best = -1; bf = 0; bg = 0; br = 0; bc = 0;
        for (int rr = 0; rr < er; rr++)
          for (int cc = 0; cc < ec; cc++) begin
            idx = rr*8 + cc;
            if (opn[idx]) begin
              g = cost[idx];
              f = g + ((rr > gr) ? rr-gr : gr-rr) + ((cc > gc) ? cc-gc : gc-cc);
              if (best < 0 || f < bf || (f == bf && g > bg)) begin
                best = idx; bf = f; bg = g; br = rr; bc = cc;
              end
            end
          end
        if (best < 0) break;
        if (br == gr && bc == gc) begin
          reached = 1'b1;
          break;
        end
        opn[best] = 0; cls[best] = 1;
        // neighbour order: down, up, right, left
        for (int d = 0; d < 4; d++) begin
          tr = br + ((d == DirDown) ? 1 : (d == DirUp) ? -1 : 0);
          tc = bc + ((d == DirRight) ? 1 : (d == DirLeft) ? -1 : 0);
          if (tr >= 0 && tc >= 0 && tr < er && tc < ec) begin
            ti = tr*8 + tc;
            if (!blocked_q[ti] && !cls[ti] && (!opn[ti] || bg+1 < cost[ti])) begin
              opn[ti] = 1; cost[ti] = bg + 1; dir[ti] = d;
            end
          end
        end
      end
    end
    if (!reached) begin
      o = '0; o.last = 1'b1;
      path_q.insert(path_q.size(), o);
      return;
    end
    // walk back from the goal, then emit start first
    tr = gr; tc = gc;
    forever begin
      trail.push_front(tr*8 + tc);
      if ((tr == sr && tc == sc) || trail.size() >= 64) break;
      n = dir[tr*8+tc];
      tr -= (n == DirDown) ? 1 : (n == DirUp) ? -1 : 0;
      tc -= (n == DirRight) ? 1 : (n == DirLeft) ? -1 : 0;
      if (tr < 0 || tc < 0 || tr >= er || tc >= ec) break;
    end
    foreach (trail[k]) begin
      o.path_row = 3'(trail[k] / 8);
      o.path_col = 3'(trail[k] % 8);
      o.found    = 1'b1;
      o.last     = (k == trail.size() - 1);
      path_q.insert(path_q.size(), o);
    end
  endfunction

  // Valid stays high across back-to-back requests; drop it only on a gap
  task automatic send_req(input req_t r);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    // request taken at this edge: update the predictor
    if (r.op == OpLoad) blocked_q[r.cell_row*8 + r.cell_col] = r.cell_blocked;
    else predict_path(r);
  endtask

  // Register writes only while idle
  task automatic write_reg(input logic idx, input logic [3:0] val);
    req_if.valid <= 1'b0;
    wait (path_q.size() == 0);
    repeat (8) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CfgRows) rows_q = val; else rows_q = rows_q;
    if (idx == CfgCols) cols_q = val;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic req_t mk_load(input int r, input int c, input bit b);
    req_t x;
    x = 20'($urandom());
    x.op = OpLoad; x.cell_row = 3'(r); x.cell_col = 3'(c); x.cell_blocked = b;
    return x;
  endfunction

  function automatic req_t mk_search(input int sr, input int sc, input int gr,
                                     input int gc);
    req_t x;
    x = 20'($urandom());
    x.op = OpSearch; x.start_row = 3'(sr); x.start_col = 3'(sc);
    x.goal_row = 3'(gr); x.goal_col = 3'(gc);
    return x;
  endfunction

  // Result side: draw a wait per result, long hold when asked
  initial begin
    int wait_c;
    wait_c = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) wait_c = $urandom_range(0, 14);
      if (hold_rsp || wait_c > 0) begin
        rsp_if.ready <= 1'b0;
        if (!hold_rsp) wait_c--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Count the long hold in its own process
  initial begin
    hold_rsp = 1'b0;
    wait (hold_cycles > 0);
    hold_rsp = 1'b1;
    repeat (hold_cycles) @(posedge clk_i);
    hold_rsp = 1'b0;
  end

  // Compare each accepted result with the oldest expected path cell
  always @(posedge clk_i) begin
    rsp_t exp_c;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (path_q.size() == 0) begin
        $error("unexpected result %p", rsp_if.payload);
        fail_cnt++;
      end else begin
        exp_c = path_q.pop_front();
        if (rsp_if.payload.path_row !== exp_c.path_row) begin
          $error("path_row exp %0d got %0d", exp_c.path_row, rsp_if.payload.path_row);
          fail_cnt++;
        end
        if (rsp_if.payload.path_col !== exp_c.path_col) begin
          $error("path_col exp %0d got %0d", exp_c.path_col, rsp_if.payload.path_col);
          fail_cnt++;
        end
        if (rsp_if.payload.found !== exp_c.found) begin
          $error("found exp %0d got %0d", exp_c.found, rsp_if.payload.found);
          fail_cnt++;
        end
        if (rsp_if.payload.last !== exp_c.last) begin
          $error("last exp %0d got %0d", exp_c.last, rsp_if.payload.last);
          fail_cnt++;
        end
      end
    end
  end

  // Directed table: op, row/col pairs; expected single result only where obvious
  typedef struct {
    req_t r;
    bit   typed;   // expected result given in the table
    rsp_t want;
  } row_t;

  row_t dir_tab [$];
  req_t rq;
  int   wall_col;

  function automatic void add_row(input req_t r, input bit typed, input rsp_t want);
    row_t x;
    x.r = r; x.typed = typed; x.want = want;
    dir_tab.insert(dir_tab.size(), x);
  endfunction

  initial begin
    fail_cnt = 0;
    hold_cycles = 0;
    rows_q = 4'd8;
    cols_q = 4'd8;
    foreach (blocked_q[i]) blocked_q[i] = 1'b0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CfgRows;
    cfg_if.data = '0;

    // found=0 single results, start equals goal, extremes, blocked cases
    add_row(mk_search(0, 0, 0, 0), 1, '{0, 0, 1, 1});
    add_row(mk_search(7, 7, 7, 7), 1, '{7, 7, 1, 1});
    add_row(mk_search(0, 0, 7, 7), 0, '0);
    add_row(mk_search(7, 7, 0, 0), 0, '0);
    add_row(mk_load(3, 3, 1), 0, '0);
    add_row(mk_search(3, 3, 3, 5), 0, '0);   // blocked start
    add_row(mk_search(3, 0, 3, 3), 1, '{0, 0, 0, 1}); // blocked goal
    add_row(mk_search(3, 3, 3, 3), 1, '{3, 3, 1, 1});
    add_row(mk_load(0, 1, 1), 0, '0);
    add_row(mk_load(1, 0, 1), 0, '0);
    add_row(mk_search(0, 0, 5, 5), 1, '{0, 0, 0, 1}); // boxed in
    add_row(mk_search(5, 5, 0, 0), 1, '{0, 0, 0, 1});
    add_row(mk_load(0, 1, 0), 0, '0);
    add_row(mk_load(1, 0, 0), 0, '0);
    add_row(mk_load(3, 3, 0), 0, '0);
    add_row(mk_search(0, 7, 7, 0), 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].r);
      if (dir_tab[i].typed && dir_tab[i].r.op == OpSearch) begin
        // table value must agree with the predictor's single result
        if (path_q.size() == 0 || path_q[$] != dir_tab[i].want) begin
          $error("table row %0d disagrees with predictor", i);
          fail_cnt++;
        end
      end
    end

    // Sizes: endpoints outside the grid in use, empty grid, single cell, sizes above 8
    write_reg(CfgRows, 4'd4);
    write_reg(CfgCols, 4'd3);
    send_req(mk_search(0, 0, 3, 2));
    send_req(mk_search(0, 0, 4, 2));
    send_req(mk_search(0, 3, 0, 0));
    write_reg(CfgRows, 4'd0);
    send_req(mk_search(0, 0, 0, 0));
    write_reg(CfgRows, 4'd1);
    write_reg(CfgCols, 4'd1);
    send_req(mk_search(0, 0, 0, 0));
    write_reg(CfgRows, 4'd15);
    write_reg(CfgCols, 4'd15);
    send_req(mk_search(0, 0, 7, 7));

    // Pressure: long result stall while searches queue behind it
    hold_cycles = 6000;
    for (int i = 0; i < 4; i++)
      send_req(mk_search($urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(0, 7), $urandom_range(0, 7)));
    // pause the sender until everything has drained
    req_if.valid <= 1'b0;
    wait (path_q.size() == 0);

    // Random part: mostly sparse maps with a few walls, then searches
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CfgRows, 4'd8); write_reg(CfgCols, 4'd8);
        end
        1: begin
          write_reg(CfgRows, 4'd5); write_reg(CfgCols, 4'd7);
        end
        2: begin
          write_reg(CfgRows, 4'd8); write_reg(CfgCols, 4'd2);
        end
        default: begin
          write_reg(CfgRows, 4'd8); write_reg(CfgCols, 4'd8);
        end
      endcase
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          send_req(mk_load($urandom_range(0, 7), $urandom_range(0, 7),
                           $urandom_range(0, 3) == 0));
        end else if ($urandom_range(0, 5) == 0) begin
          send_req(mk_search($urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom_range(0, 7), $urandom_range(0, 7)));
        end else begin
          send_req(mk_search($urandom_range(0, 4), $urandom_range(0, 1),
                             $urandom_range(0, 4), $urandom_range(0, 1)));
        end
      end
      // a wall with one gap, to force detours
      wall_col = $urandom_range(1, 6);
      for (int rr = 0; rr < 8; rr++) send_req(mk_load(rr, wall_col, rr != 5));
      send_req(mk_search($urandom_range(0, 7), 0, $urandom_range(0, 7), 7));
      for (int rr = 0; rr < 8; rr++) send_req(mk_load(rr, wall_col, 1'b0));
    end

    req_if.valid <= 1'b0;
    wait (path_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/gas_pkg.sv
src/gas_if.sv
src/gas_cell.sv
src/gas_seq.sv
src/grid_astar_path_search_unit.sv
dv/tb_grid_astar_path_search_unit.sv
